### src/cdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CD TOC parser and track query block.
// No dependencies; cdt_loader, cdt_query and the top level import this package.
package cdt_pkg;

  localparam int TRACK_SLOTS_DEF = 100;
  localparam logic [7:0] LEAD_OUT_NUM = 8'hAA;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam int ENTRY_W = 40;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_TRUNC = 2'd1,
    ST_CORRUPT = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0] adr;
    logic [3:0] ctl;
    logic [31:0] lba;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic we;
    logic [7:0] idx;
    entry_t data;
  } tbl_wr_t;

  typedef struct packed {
    logic done;
    status_t status;
    logic [7:0] first_track;
    logic [7:0] final_track;
  } ld_res_t;

  typedef struct packed {
    logic [3:0] ctl;
    logic [3:0] adr;
    logic [31:0] addr;
    logic [31:0] len;
  } q_ans_t;

endpackage

### src/cdt_in_if.sv
`timescale 1ns / 1ps
// Input channel: one load byte or one track query per item.
// Depends on nothing.
interface cdt_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] data_byte;
  logic last_byte;
  logic [7:0] query_track;

  modport source (output valid, cmd, data_byte, last_byte, query_track, input ready);
  modport sink (input valid, cmd, data_byte, last_byte, query_track, output ready);
endinterface

### src/cdt_out_if.sv
`timescale 1ns / 1ps
// Output channel: one load status or query answer per item.
// Depends on nothing.
interface cdt_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic [1:0] status;
  logic [7:0] first_track;
  logic [7:0] final_track;
  logic [3:0] control_bits;
  logic [3:0] adr_bits;
  logic [31:0] start_address;
  logic [31:0] track_length;

  modport source (output valid, kind, status, first_track, final_track, control_bits,
                  adr_bits, start_address, track_length, input ready);
  modport sink (input valid, kind, status, first_track, final_track, control_bits,
                adr_bits, start_address, track_length, output ready);
endinterface

### src/cdt_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module cdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/cdt_loader.sv
`timescale 1ns / 1ps
// TOC byte parser: header fields, descriptor assembly, table writes and load status.
// Depends on cdt_pkg.
module cdt_loader import cdt_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic ld_en,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  output logic [7:0] first_track,
  output logic [7:0] final_track,
  output tbl_wr_t tbl_wr,
  output ld_res_t ld_res
);

  localparam logic [8:0] SLOTS9 = 9'(TRACK_SLOTS);

  logic [16:0] byte_count, byte_count_next, count_inc;
  logic [15:0] declared_length, declared_length_next;
  logic [55:0] desc_buf, desc_buf_next;
  logic [7:0] first_next, final_next;
  logic [63:0] desc_full;
  logic [7:0] num;
  logic store;

  always_comb begin
    declared_length_next = declared_length;
    desc_buf_next = desc_buf;
    first_next = first_track;
    final_next = final_track;
    store = 1'b0;
    desc_full = {desc_buf, data_byte};
    if (byte_count == 17'd0) begin
      declared_length_next = {data_byte, 8'd0};
      desc_buf_next = '0;
      first_next = '0;
      final_next = '0;
    end else if (byte_count == 17'd1) begin
      declared_length_next = {declared_length[15:8], data_byte};
    end else if (byte_count == 17'd2) begin
      first_next = data_byte;
    end else if (byte_count == 17'd3) begin
      final_next = data_byte;
    end else if (byte_count < ({1'b0, declared_length} + 17'd2)) begin
      desc_buf_next = desc_full[55:0];
      store = (byte_count[2:0] == 3'd3);
    end

    num = (desc_full[47:40] == LEAD_OUT_NUM) ? 8'd0 : desc_full[47:40];
    tbl_wr.clr = ld_en && (byte_count == 17'd0);
    tbl_wr.we = ld_en && store && ({1'b0, num} < SLOTS9);
    tbl_wr.idx = num;
    tbl_wr.data.adr = desc_full[55:52];
    tbl_wr.data.ctl = desc_full[51:48];
    tbl_wr.data.lba = desc_full[31:0];

    count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
    byte_count_next = last_byte ? 17'd0 : count_inc;

    ld_res.done = ld_en && last_byte;
    ld_res.first_track = first_next;
    ld_res.final_track = final_next;
    if (count_inc < 17'd4 || (count_inc - 17'd2) < {1'b0, declared_length_next}) begin
      ld_res.status = ST_TRUNC;
    end else if (declared_length_next[2:0] != 3'd2) begin
      ld_res.status = ST_CORRUPT;
    end else begin
      ld_res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      declared_length <= '0;
      desc_buf <= '0;
      first_track <= '0;
      final_track <= '0;
    end else if (ld_en) begin
      byte_count <= byte_count_next;
      declared_length <= declared_length_next;
      desc_buf <= desc_buf_next;
      first_track <= first_next;
      final_track <= final_next;
    end
  end

endmodule

### src/cdt_query.sv
`timescale 1ns / 1ps
// Track table memory with per-slot valid bits, and the two-read query datapath.
// Depends on cdt_pkg and cdt_ram.
module cdt_query import cdt_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_start,
  input  logic [7:0] query_track,
  input  logic [7:0] first_track,
  input  logic [7:0] final_track,
  input  tbl_wr_t tbl_wr,
  output logic q_done,
  output q_ans_t ans
);

  localparam int AW = $clog2(TRACK_SLOTS);
  localparam logic [8:0] SLOTS9 = 9'(TRACK_SLOTS);

  logic [TRACK_SLOTS-1:0] valid;
  logic [8:0] t9, t_inc;
  logic in_rng, below, a_ok, b_ok;
  logic [AW-1:0] a_idx, b_idx;
  logic hit_a, hit_lo, len_en, va, vb;
  logic [ENTRY_W-1:0] rd_a, rd_b;
  entry_t da, db;

  always_comb begin
    t9 = {1'b0, query_track};
    t_inc = t9 + 9'd1;
    in_rng = (query_track >= first_track) && (query_track <= final_track);
    below = (query_track >= first_track) && (query_track < final_track);
    a_ok = t9 < SLOTS9;
    b_ok = below ? (t_inc < SLOTS9) : 1'b1;
    a_idx = query_track[AW-1:0];
    b_idx = below ? t_inc[AW-1:0] : '0;
  end

  cdt_ram #(.WIDTH(ENTRY_W), .DEPTH(TRACK_SLOTS)) u_ram (
    .clk(clk),
    .we(tbl_wr.we),
    .waddr(tbl_wr.idx[AW-1:0]),
    .wdata(tbl_wr.data),
    .raddr_a(a_idx),
    .raddr_b(b_idx),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      q_done <= 1'b0;
    end else begin
      if (tbl_wr.clr) begin
        valid <= '0;
      end else if (tbl_wr.we) begin
        valid[tbl_wr.idx[AW-1:0]] <= 1'b1;
      end
      q_done <= q_start;
    end
    if (q_start) begin
      hit_a <= in_rng;
      hit_lo <= !in_rng && (query_track == LEAD_OUT_NUM);
      len_en <= below || (query_track == final_track);
      va <= a_ok ? valid[a_idx] : 1'b0;
      vb <= b_ok ? valid[b_idx] : 1'b0;
    end
  end

  always_comb begin
    da = va ? entry_t'(rd_a) : '0;
    db = vb ? entry_t'(rd_b) : '0;
    if (hit_a) begin
      ans.ctl = da.ctl;
      ans.adr = da.adr;
      ans.addr = da.lba;
    end else if (hit_lo) begin
      ans.ctl = db.ctl;
      ans.adr = db.adr;
      ans.addr = db.lba;
    end else begin
      ans.ctl = '0;
      ans.adr = '0;
      ans.addr = '0;
    end
    ans.len = len_en ? (db.lba - da.lba) : '0;
  end

endmodule

### src/cd_toc_parse_and_query.sv
`timescale 1ns / 1ps
// CD TOC parser and track query top level. Depends on cdt_pkg, the channel
// interfaces, cdt_loader and cdt_query. The status item for a load is registered
// and valid in the cycle after its last byte is accepted. A query runs the track
// memory read and then the length subtraction; the input stalls during the subtraction.
// Synchronous reset clears the header registers, byte count and all table valid bits.
module cd_toc_parse_and_query import cdt_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  cdt_in_if.sink req,
  cdt_out_if.source rsp
);

  logic ld_en, q_start, q_done, accept;
  logic [7:0] first_track, final_track;
  tbl_wr_t tbl_wr;
  ld_res_t ld_res;
  q_ans_t ans;

  logic out_valid, kind;
  logic [1:0] status;
  logic [7:0] first_out, final_out;
  logic [3:0] ctl_out, adr_out;
  logic [31:0] addr_out, len_out;

  assign req.ready = !q_done && (!out_valid || rsp.ready);
  assign accept = req.valid && req.ready;
  assign ld_en = accept && (req.cmd == CMD_LOAD);
  assign q_start = accept && (req.cmd == CMD_QUERY);

  cdt_loader #(.TRACK_SLOTS(TRACK_SLOTS)) u_loader (
    .clk(clk),
    .rst(rst),
    .ld_en(ld_en),
    .data_byte(req.data_byte),
    .last_byte(req.last_byte),
    .first_track(first_track),
    .final_track(final_track),
    .tbl_wr(tbl_wr),
    .ld_res(ld_res)
  );

  cdt_query #(.TRACK_SLOTS(TRACK_SLOTS)) u_query (
    .clk(clk),
    .rst(rst),
    .q_start(q_start),
    .query_track(req.query_track),
    .first_track(first_track),
    .final_track(final_track),
    .tbl_wr(tbl_wr),
    .q_done(q_done),
    .ans(ans)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_res.done || q_done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (ld_res.done) begin
      kind <= KIND_STATUS;
      status <= ld_res.status;
      first_out <= ld_res.first_track;
      final_out <= ld_res.final_track;
      ctl_out <= '0;
      adr_out <= '0;
      addr_out <= '0;
      len_out <= '0;
    end else if (q_done) begin
      kind <= KIND_QUERY;
      status <= ST_OK;
      first_out <= first_track;
      final_out <= final_track;
      ctl_out <= ans.ctl;
      adr_out <= ans.adr;
      addr_out <= ans.addr;
      len_out <= ans.len;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.kind = kind;
  assign rsp.status = status;
  assign rsp.first_track = first_out;
  assign rsp.final_track = final_out;
  assign rsp.control_bits = ctl_out;
  assign rsp.adr_bits = adr_out;
  assign rsp.start_address = addr_out;
  assign rsp.track_length = len_out;

endmodule
